// ===== hw/rtl/qvr_pkg.sv =====
package qvr_pkg;

  // register stages ahead of the divider
  localparam int FRONT_STAGES = 6;

  // per-word status travelling alongside the divider
  typedef struct packed {
    logic       zero;
    logic [2:0] neg;
    logic [2:0] over;
  } qvr_flags_t;

endpackage

// ===== hw/rtl/qvr_in_if.sv =====
interface qvr_in_if #(
  parameter int VB = 16,
  parameter int QB = 16
) ();
  logic                 valid;
  logic                 ready;
  logic signed [VB-1:0] vec_x;
  logic signed [VB-1:0] vec_y;
  logic signed [VB-1:0] vec_z;
  logic signed [QB-1:0] quat_w;
  logic signed [QB-1:0] quat_x;
  logic signed [QB-1:0] quat_y;
  logic signed [QB-1:0] quat_z;

  modport source (output valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
                  input ready);
  modport sink (input valid, vec_x, vec_y, vec_z, quat_w, quat_x, quat_y, quat_z,
                output ready);
endinterface

// ===== hw/rtl/qvr_out_if.sv =====
interface qvr_out_if #(
  parameter int VB = 16
) ();
  logic                 valid;
  logic                 ready;
  logic signed [VB-1:0] rot_x;
  logic signed [VB-1:0] rot_y;
  logic signed [VB-1:0] rot_z;
  logic                 zero_quat;
  logic                 clipped;

  modport source (output valid, rot_x, rot_y, rot_z, zero_quat, clipped, input ready);
  modport sink (input valid, rot_x, rot_y, rot_z, zero_quat, clipped, output ready);
endinterface

// ===== hw/rtl/qvr_front.sv =====
module qvr_front #(
  parameter int VB = 16,
  parameter int QB = 16,
  parameter int TW = 34,
  parameter int NW = 34,
  parameter int RW = 52,
  parameter int SW = 53,
  parameter int DW = 50
) (
  input  logic                   clk,
  input  logic [5:0]             en,
  input  logic signed [VB-1:0]   vec_x,
  input  logic signed [VB-1:0]   vec_y,
  input  logic signed [VB-1:0]   vec_z,
  input  logic signed [QB-1:0]   quat_w,
  input  logic signed [QB-1:0]   quat_x,
  input  logic signed [QB-1:0]   quat_y,
  input  logic signed [QB-1:0]   quat_z,
  output logic [DW-1:0]          rem [3],
  output logic [NW-1:0]          n_out,
  output qvr_pkg::qvr_flags_t    flags
);

  localparam int PW = TW + QB + 2;
  localparam int CW = (SW > DW) ? SW : DW;

  logic signed [VB-1:0]      vv [3];
  logic signed [QB-1:0]      qq [4];

  // stage a: vector and square products
  logic signed [QB+VB-1:0]   pv_nxt [12];
  logic signed [QB+VB-1:0]   pv_r [12];
  logic signed [2*QB-1:0]    sq_nxt [4];
  logic signed [2*QB-1:0]    sq_r [4];
  logic signed [QB-1:0]      qa_r [4];

  // stage b: norm and t = q (0,v)
  logic signed [TW-1:0]      t_nxt [4];
  logic signed [TW-1:0]      t_r [4];
  logic [NW-1:0]             n_b_nxt;
  logic [NW-1:0]             n_b_r;
  logic signed [QB-1:0]      qb_r [4];

  // stage c: t times conjugate products
  logic signed [PW-1:0]      rp_full [12];
  logic signed [RW-1:0]      rp_r [12];
  logic [NW-1:0]             n_c_r;

  // stage d: vector part sums
  logic signed [RW-1:0]      r_nxt [3];
  logic signed [RW-1:0]      r_r [3];
  logic [NW-1:0]             n_d_r;

  // stage e: magnitude plus half the norm
  logic [RW-1:0]             mag [3];
  logic [SW-1:0]             s_nxt [3];
  logic [SW-1:0]             s_r [3];
  logic [2:0]                neg_e_r;
  logic [NW-1:0]             n_e_r;
  logic                      zero_e_r;

  // stage f: range check and divider seed
  logic [DW-1:0]             rem_r [3];
  logic [NW-1:0]             n_f_r;
  qvr_pkg::qvr_flags_t       flags_r;
  logic [2:0]                over_nxt;
  logic [CW-1:0]             nlim;

  assign vv[0] = vec_x;
  assign vv[1] = vec_y;
  assign vv[2] = vec_z;
  assign qq[0] = quat_w;
  assign qq[1] = quat_x;
  assign qq[2] = quat_y;
  assign qq[3] = quat_z;

  // stage a products
  always_comb begin
    for (int qi = 0; qi < 4; qi++) begin
      sq_nxt[qi] = qq[qi] * qq[qi];
      for (int vi = 0; vi < 3; vi++) begin
        pv_nxt[qi*3+vi] = qq[qi] * vv[vi];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      pv_r <= pv_nxt;
      sq_r <= sq_nxt;
      qa_r <= qq;
    end
  end

  // stage b sums, products indexed quat*3 + vec
  always_comb begin
    t_nxt[0] = -(TW'(pv_r[3]) + TW'(pv_r[7]) + TW'(pv_r[11]));
    t_nxt[1] = TW'(pv_r[0]) + TW'(pv_r[8]) - TW'(pv_r[10]);
    t_nxt[2] = TW'(pv_r[1]) - TW'(pv_r[5]) + TW'(pv_r[9]);
    t_nxt[3] = TW'(pv_r[2]) + TW'(pv_r[4]) - TW'(pv_r[6]);
    n_b_nxt  = NW'(unsigned'(sq_r[0])) + NW'(unsigned'(sq_r[1]))
             + NW'(unsigned'(sq_r[2])) + NW'(unsigned'(sq_r[3]));
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      t_r   <= t_nxt;
      n_b_r <= n_b_nxt;
      qb_r  <= qa_r;
    end
  end

  // stage c products
  always_comb begin
    rp_full[0]  = t_r[1] * qb_r[0];
    rp_full[1]  = t_r[0] * qb_r[1];
    rp_full[2]  = t_r[2] * qb_r[3];
    rp_full[3]  = t_r[3] * qb_r[2];
    rp_full[4]  = t_r[2] * qb_r[0];
    rp_full[5]  = t_r[0] * qb_r[2];
    rp_full[6]  = t_r[1] * qb_r[3];
    rp_full[7]  = t_r[3] * qb_r[1];
    rp_full[8]  = t_r[3] * qb_r[0];
    rp_full[9]  = t_r[0] * qb_r[3];
    rp_full[10] = t_r[1] * qb_r[2];
    rp_full[11] = t_r[2] * qb_r[1];
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 12; k++) begin
        rp_r[k] <= rp_full[k][RW-1:0];
      end
      n_c_r <= n_b_r;
    end
  end

  // stage d sums
  always_comb begin
    r_nxt[0] = rp_r[0] - rp_r[1] - rp_r[2] + rp_r[3];
    r_nxt[1] = rp_r[4] - rp_r[5] + rp_r[6] - rp_r[7];
    r_nxt[2] = rp_r[8] - rp_r[9] - rp_r[10] + rp_r[11];
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      r_r   <= r_nxt;
      n_d_r <= n_c_r;
    end
  end

  // stage e rounding offset
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mag[c]   = r_r[c][RW-1] ? unsigned'(-r_r[c]) : unsigned'(r_r[c]);
      s_nxt[c] = SW'(mag[c]) + SW'(n_d_r >> 1);
    end
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s_r      <= s_nxt;
      neg_e_r  <= {r_r[2][RW-1], r_r[1][RW-1], r_r[0][RW-1]};
      n_e_r    <= n_d_r;
      zero_e_r <= (n_d_r == '0);
    end
  end

  // stage f quotient range check
  always_comb begin
    nlim = CW'(n_e_r) << VB;
    for (int c = 0; c < 3; c++) begin
      over_nxt[c] = CW'(s_r[c]) >= nlim;
    end
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      for (int c = 0; c < 3; c++) begin
        rem_r[c] <= DW'(s_r[c]);
      end
      n_f_r         <= n_e_r;
      flags_r.zero  <= zero_e_r;
      flags_r.neg   <= neg_e_r;
      flags_r.over  <= over_nxt;
    end
  end

  assign rem   = rem_r;
  assign n_out = n_f_r;
  assign flags = flags_r;

endmodule

// ===== hw/rtl/qvr_div.sv =====
module qvr_div #(
  parameter int VB = 16,
  parameter int NW = 34,
  parameter int DW = 50
) (
  input  logic                 clk,
  input  logic [VB-1:0]        en,
  input  logic [DW-1:0]        rem_in [3],
  input  logic [NW-1:0]        n_in,
  input  qvr_pkg::qvr_flags_t  flags_in,
  output logic [VB-1:0]        quo [3],
  output qvr_pkg::qvr_flags_t  flags_out
);

  logic [DW-1:0]        rem_w [VB+1][3];
  logic [VB-1:0]        q_w [VB+1][3];
  logic [NW-1:0]        n_w [VB+1];
  qvr_pkg::qvr_flags_t  fl_w [VB+1];

  assign rem_w[0] = rem_in;
  assign n_w[0]   = n_in;
  assign fl_w[0]  = flags_in;
  assign q_w[0]   = '{default: '0};

  // one restoring step per stage, most significant quotient bit first
  for (genvar g = 0; g < VB; g++) begin : g_step
    localparam int SH = VB - 1 - g;

    logic [DW-1:0]        d;
    logic [DW-1:0]        rem_nxt [3];
    logic [VB-1:0]        q_nxt [3];
    logic [DW-1:0]        rem_r [3];
    logic [VB-1:0]        q_r [3];
    logic [NW-1:0]        n_r;
    qvr_pkg::qvr_flags_t  fl_r;

    always_comb begin
      d = DW'(n_w[g]) << SH;
      for (int c = 0; c < 3; c++) begin
        if (rem_w[g][c] >= d) begin
          rem_nxt[c] = rem_w[g][c] - d;
          q_nxt[c]   = q_w[g][c] | (VB'(1) << SH);
        end else begin
          rem_nxt[c] = rem_w[g][c];
          q_nxt[c]   = q_w[g][c];
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[g]) begin
        rem_r <= rem_nxt;
        q_r   <= q_nxt;
        n_r   <= n_w[g];
        fl_r  <= fl_w[g];
      end
    end

    assign rem_w[g+1] = rem_r;
    assign q_w[g+1]   = q_r;
    assign n_w[g+1]   = n_r;
    assign fl_w[g+1]  = fl_r;
  end

  assign quo       = q_w[VB];
  assign flags_out = fl_w[VB];

endmodule

// ===== hw/rtl/quaternion_vector_rotate_core.sv =====
// Quaternion vector rotation, v' = q (0,v) conj(q) / |q|^2.
// in_ch carries one word per item: a signed vector and a signed Q1.14
// quaternion that need not be unit length. out_ch returns the rotated
// vector, rounded to nearest with ties away from zero and saturated,
// plus zero_quat (all-zero quaternion, outputs forced to zero) and
// clipped (some component saturated).
// Both channels use valid/ready; a word moves when both are high.
// Throughput is one word per cycle while out_ch is ready. The pipeline is
// six stages of products and sums, then one restoring divider stage per
// quotient bit, then the saturation register.
// Each stage holds a valid bit; when out_ch stalls, stages that hold a
// word freeze while empty stages ahead of them still fill, so in_ch keeps
// accepting until the pipeline is full. Nothing is lost or repeated.
// Synchronous reset clears every valid bit; data registers are not reset.
module quaternion_vector_rotate_core #(
  parameter int VEC_BITS       = 16,
  parameter int QUAT_FRAC_BITS = 14
) (
  input  logic      clk,
  input  logic      rst_n,
  qvr_in_if.sink    in_ch,
  qvr_out_if.source out_ch
);

  localparam int QB  = QUAT_FRAC_BITS + 2;
  localparam int TW  = (QB + VEC_BITS + 2 > 64) ? 64 : QB + VEC_BITS + 2;
  localparam int NW  = (2 * QB + 2 > 64) ? 64 : 2 * QB + 2;
  localparam int RW  = (TW + QB + 2 > 64) ? 64 : TW + QB + 2;
  localparam int MW  = (RW > NW) ? RW : NW;
  localparam int SW  = (MW + 1 > 64) ? 64 : MW + 1;
  localparam int DW  = NW + VEC_BITS;
  localparam int FS  = qvr_pkg::FRONT_STAGES;
  localparam int NS  = FS + VEC_BITS + 1;

  localparam logic [VEC_BITS-1:0] LIM  = {1'b1, {(VEC_BITS-1){1'b0}}};
  localparam logic [VEC_BITS-1:0] PMAX = {1'b0, {(VEC_BITS-1){1'b1}}};

  logic [NS-1:0]        v_r;
  logic [NS:0]          en;
  logic [DW-1:0]        rem [3];
  logic [NW-1:0]        n_f;
  qvr_pkg::qvr_flags_t  fl_f;
  logic [VEC_BITS-1:0]  quo [3];
  qvr_pkg::qvr_flags_t  fl_q;
  logic [VEC_BITS-1:0]  rot_nxt [3];
  logic [VEC_BITS-1:0]  rot_r [3];
  logic                 clip_nxt;
  logic                 clip_r;
  logic                 zero_r;

  // stage enables, ready ripples back from the output
  always_comb begin
    en[NS] = out_ch.ready;
    for (int k = NS - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[0]) begin
        v_r[0] <= in_ch.valid;
      end
      for (int k = 1; k < NS; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign in_ch.ready = en[0];

  qvr_front #(
    .VB (VEC_BITS),
    .QB (QB),
    .TW (TW),
    .NW (NW),
    .RW (RW),
    .SW (SW),
    .DW (DW)
  ) u_front (
    .clk    (clk),
    .en     (en[FS-1:0]),
    .vec_x  (in_ch.vec_x),
    .vec_y  (in_ch.vec_y),
    .vec_z  (in_ch.vec_z),
    .quat_w (in_ch.quat_w),
    .quat_x (in_ch.quat_x),
    .quat_y (in_ch.quat_y),
    .quat_z (in_ch.quat_z),
    .rem    (rem),
    .n_out  (n_f),
    .flags  (fl_f)
  );

  qvr_div #(
    .VB (VEC_BITS),
    .NW (NW),
    .DW (DW)
  ) u_div (
    .clk       (clk),
    .en        (en[FS+VEC_BITS-1:FS]),
    .rem_in    (rem),
    .n_in      (n_f),
    .flags_in  (fl_f),
    .quo       (quo),
    .flags_out (fl_q)
  );

  // sign restore and saturation
  always_comb begin
    clip_nxt = 1'b0;
    for (int c = 0; c < 3; c++) begin
      if (fl_q.zero) begin
        rot_nxt[c] = '0;
      end else if (fl_q.neg[c]) begin
        if (fl_q.over[c] || quo[c] > LIM) begin
          rot_nxt[c] = LIM;
          clip_nxt   = 1'b1;
        end else begin
          rot_nxt[c] = ~quo[c] + VEC_BITS'(1);
        end
      end else begin
        if (fl_q.over[c] || quo[c] > PMAX) begin
          rot_nxt[c] = PMAX;
          clip_nxt   = 1'b1;
        end else begin
          rot_nxt[c] = quo[c];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[NS-1]) begin
      rot_r  <= rot_nxt;
      clip_r <= clip_nxt && !fl_q.zero;
      zero_r <= fl_q.zero;
    end
  end

  assign out_ch.valid     = v_r[NS-1];
  assign out_ch.rot_x     = signed'(rot_r[0]);
  assign out_ch.rot_y     = signed'(rot_r[1]);
  assign out_ch.rot_z     = signed'(rot_r[2]);
  assign out_ch.zero_quat = zero_r;
  assign out_ch.clipped   = clip_r;

  // a zero quaternion never reports saturation
  a_zero_no_clip: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> !(out_ch.zero_quat && out_ch.clipped))
    else $error("zero_quat and clipped both set");

  // a zero quaternion forces the vector to zero
  a_zero_out: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.zero_quat) |->
      (rot_r[0] == '0 && rot_r[1] == '0 && rot_r[2] == '0))
    else $error("zero quaternion with non-zero vector");

  // a clipped word has a component pinned at a rail
  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.clipped) |->
      (rot_r[0] == LIM || rot_r[0] == PMAX || rot_r[1] == LIM || rot_r[1] == PMAX ||
       rot_r[2] == LIM || rot_r[2] == PMAX))
    else $error("clipped without saturated component");

  // a stalled output stage keeps its valid bit and its x component
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (v_r[NS-1] && !out_ch.ready) |=> (v_r[NS-1] && $stable(rot_r[0])))
    else $error("output word lost under stall");

endmodule
